// ----- rtl/llfs_pkg.sv -----
// ----------------------------------------------------------------------------
// llfs_pkg
// Shared widths, register indexes and reset values of the link-loss failsafe.
// ----------------------------------------------------------------------------
package llfs_pkg;

  localparam int unsigned TIME_W  = 64;
  localparam int unsigned LIMIT_W = 32;
  localparam int unsigned STATE_W = 3;
  localparam int unsigned INDEX_W = 2;

  typedef logic [TIME_W-1:0]  time_t;
  typedef logic [LIMIT_W-1:0] limit_t;

  typedef enum logic [INDEX_W-1:0] {
    REG_TELEMETRY_TIMEOUT = 2'd0,
    REG_COMMAND_TIMEOUT   = 2'd1,
    REG_HOVER_LIMIT       = 2'd2,
    REG_LAND_LIMIT        = 2'd3
  } reg_index_t;

  localparam limit_t TELEMETRY_TIMEOUT_RST = 32'd500;
  localparam limit_t COMMAND_TIMEOUT_RST   = 32'd1000;
  localparam limit_t HOVER_LIMIT_RST       = 32'd5000;
  localparam limit_t LAND_LIMIT_RST        = 32'd10000;

endpackage

// ----- rtl/link_loss_failsafe_fsm.sv -----
// ----------------------------------------------------------------------------
// link_loss_failsafe_fsm
// Failsafe state machine for link loss: records telemetry and command
// arrival times and steps through init, ok, hover, land and lost.
// ----------------------------------------------------------------------------
//
//  channel | handshake                 | payload
//  --------+---------------------------+------------------------------------
//  item    | item_valid / item_stall   | mode, now_time, telemetry_seen,
//          |                           | command_seen
//  result  | result_valid/result_stall | recovery_state
//  cfg     | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
//  One item per cycle while item_stall is low; each result is registered in
//  the result register or the skid. The state update (three 64-bit
//  subtract/compares and the next-state mux) sits between the item beat
//  and the state and result registers. A two-entry output (result register
//  plus skid) keeps item beats flowing while one result waits; item_stall
//  rises only when both are full. Reset (rst, synchronous) clears arrival
//  times, entry time and state, and restores the register reset values.
// ----------------------------------------------------------------------------
module link_loss_failsafe_fsm
  import llfs_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // item channel
  input  logic                item_valid,
  output logic                item_stall,
  input  logic                mode,
  input  logic [TIME_W-1:0]   now_time,
  input  logic                telemetry_seen,
  input  logic                command_seen,
  // result channel
  output logic                result_valid,
  input  logic                result_stall,
  output logic [STATE_W-1:0]  recovery_state,
  // configuration channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [INDEX_W-1:0]  cfg_index,
  input  logic [LIMIT_W-1:0]  cfg_data
);

  typedef enum logic [STATE_W-1:0] {
    ST_INIT  = 3'd0,
    ST_OK    = 3'd1,
    ST_HOVER = 3'd2,
    ST_LAND  = 3'd3,
    ST_LOST  = 3'd4
  } state_t;

  limit_t telemetry_timeout;
  limit_t command_timeout;
  limit_t hover_limit;
  limit_t land_limit;

  time_t  last_telemetry_time;
  time_t  last_command_time;
  time_t  entry_time;
  state_t cur_state;

  state_t state_next;
  time_t  entry_time_next;

  logic   skid_valid;
  state_t skid_state;
  state_t out_state;

  logic   item_accept;
  logic   cfg_accept;

  time_t  tel_age;
  time_t  cmd_age;
  time_t  dwell;
  logic   tel_known;
  logic   cmd_known;
  logic   tel_fresh;
  logic   cmd_fresh;

  assign item_stall   = skid_valid;
  assign item_accept  = item_valid && !item_stall;
  assign cfg_ready    = 1'b1;
  assign cfg_accept   = cfg_valid && cfg_ready;
  assign recovery_state = out_state;

  // ---------------- configuration registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      telemetry_timeout <= TELEMETRY_TIMEOUT_RST;
      command_timeout   <= COMMAND_TIMEOUT_RST;
      hover_limit       <= HOVER_LIMIT_RST;
      land_limit        <= LAND_LIMIT_RST;
    end else if (cfg_accept) begin
      unique case (reg_index_t'(cfg_index))
        REG_TELEMETRY_TIMEOUT: telemetry_timeout <= cfg_data;
        REG_COMMAND_TIMEOUT:   command_timeout   <= cfg_data;
        REG_HOVER_LIMIT:       hover_limit       <= cfg_data;
        REG_LAND_LIMIT:        land_limit        <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- freshness and dwell ----------------
  assign tel_age   = now_time - last_telemetry_time;
  assign cmd_age   = now_time - last_command_time;
  assign dwell     = now_time - entry_time;
  assign tel_known = (last_telemetry_time != '0);
  assign cmd_known = (last_command_time != '0);
  assign tel_fresh = tel_known && (tel_age < time_t'(telemetry_timeout));
  assign cmd_fresh = cmd_known && (cmd_age < time_t'(command_timeout));

  // ---------------- next state on evaluation ----------------
  always_comb begin
    state_next      = cur_state;
    entry_time_next = entry_time;
    if (mode) begin
      priority if (tel_known && !tel_fresh) begin
        state_next = ST_LOST;
      end else if (!tel_known) begin
        state_next = ST_INIT;
      end else if (!cmd_known) begin
        if (cur_state != ST_INIT) begin
          state_next      = ST_INIT;
          entry_time_next = now_time;
        end
      end else begin
        unique case (cur_state)
          ST_INIT: begin
            if (tel_fresh && cmd_fresh) begin
              state_next      = ST_OK;
              entry_time_next = '0;
            end
          end
          ST_OK: begin
            if (!cmd_fresh) begin
              state_next      = ST_HOVER;
              entry_time_next = now_time;
            end
          end
          ST_HOVER: begin
            if (cmd_fresh) begin
              state_next      = ST_OK;
              entry_time_next = '0;
            end else if (dwell > time_t'(hover_limit)) begin
              state_next      = ST_LAND;
              entry_time_next = now_time;
            end
          end
          ST_LAND: begin
            if (cmd_fresh) begin
              state_next      = ST_OK;
              entry_time_next = '0;
            end else if (dwell > time_t'(land_limit)) begin
              state_next = ST_LOST;
            end
          end
          ST_LOST: begin
            if (tel_fresh) begin
              state_next      = ST_INIT;
              entry_time_next = now_time;
            end
          end
          default: ;  // unused codes hold
        endcase
      end
    end
  end

  // ---------------- machine state and arrival times ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      last_telemetry_time <= '0;
      last_command_time   <= '0;
      entry_time          <= '0;
      cur_state           <= ST_INIT;
    end else if (item_accept) begin
      if (!mode && telemetry_seen) last_telemetry_time <= now_time;
      if (!mode && command_seen)   last_command_time   <= now_time;
      entry_time <= entry_time_next;
      cur_state  <= state_next;
    end
  end

  // ---------------- result register and skid ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (!result_valid || !result_stall) begin
      // result register frees up this edge: drain skid first
      if (skid_valid) begin
        out_state    <= skid_state;
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else if (item_accept) begin
        out_state    <= state_next;
        result_valid <= 1'b1;
      end else begin
        result_valid <= 1'b0;
      end
    end else if (item_accept) begin
      // hold the stalled beat, park the new one
      skid_state <= state_next;
      skid_valid <= 1'b1;
    end
  end

  // ---------------- assertions ----------------
  a_skid_implies_out : assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid holds a result while the result register is empty");

  a_accept_gives_result : assert property (@(posedge clk) disable iff (rst)
    item_accept |=> result_valid)
    else $error("accepted item left no result");

  a_record_keeps_state : assert property (@(posedge clk) disable iff (rst)
    (item_accept && !mode) |=> $stable(cur_state))
    else $error("arrival record changed the machine state");

  a_ok_entry_zero : assert property (@(posedge clk) disable iff (rst)
    (cur_state == ST_OK) |-> (entry_time == '0))
    else $error("entry time not cleared in ok");

endmodule
